FILE: hw/rtl/tdsc_pkg.sv
// tdsc_pkg: widths, constants, word layouts and shared functions of the
// TDS sample converter. Used by every module under hw/rtl and by the checker.
// Depends on nothing.
package tdsc_pkg;

	// field widths
	localparam int ADC_W    = 12;
	localparam int TEMP_W   = 12;
	localparam int VREF_W   = 13;
	localparam int OFS_W    = 14;
	localparam int GAIN_W   = 16;
	localparam int COEF_W   = 16;
	localparam int VOLT_W   = 13;
	localparam int COND_W   = 12;
	localparam int TDS_W    = 11;
	localparam int CLASS_W  = 3;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 3;

	// fixed design constants
	localparam int ADC_FULL_SCALE = 4095;
	localparam int CONDUCTIVE_MIN = 2500;
	localparam int TDS_FLOOR      = 0;
	localparam int TDS_CEILING    = 1500;
	localparam int COND_MAX       = 3000;
	localparam int FACTOR_ONE     = 1 << 20;   // Q20 unity of the compensation factor

	localparam int QC_LIM_GOOD  = 300;
	localparam int QC_LIM_FAIR  = 600;
	localparam int QC_LIM_POOR  = 900;
	localparam int QC_LIM_UNACC = 1200;
	localparam int QC_LIM_DANG  = 2000;

	// voltage: p = adc * vref, v = p / ADC_FULL_SCALE by reciprocal multiply
	localparam int PROD_W   = ADC_W + VREF_W;
	localparam int RECIP_SH = PROD_W;
	localparam int RECIP    = (1 << RECIP_SH) / ADC_FULL_SCALE;
	localparam int RECIP_W  = $clog2(RECIP + 1);
	localparam int FS_W     = $clog2(ADC_FULL_SCALE + 1);
	localparam int VQ_W     = PROD_W - FS_W + 1;

	// compensation factor F = 2^20 + coef * (temp - ref)
	localparam int DIFF_W = TEMP_W + 1;
	localparam int TP_W   = COEF_W + 1 + DIFF_W;
	localparam int F_W    = TP_W + 1;
	localparam int FMAG_W = F_W - 1;
	localparam int DEN_W  = VREF_W + FMAG_W;

	// numerator: comp * k * 2000 * 256 = (comp * k * 125) << 12
	localparam int NUM_SHIFT = 12;
	localparam int NUM_MUL   = (2000 * 256) >> NUM_SHIFT;
	localparam int NMUL_W    = $clog2(NUM_MUL + 1);
	localparam int COMP_W    = VQ_W + 2;
	localparam int CMAG_W    = COMP_W - 1;
	localparam int CK_W      = CMAG_W + GAIN_W;
	localparam int NUM_W     = CK_W + NMUL_W;
	localparam int Q_W       = NUM_SHIFT;        // quotient bits, one per divider stage

	// pipeline depth of each part
	localparam int SCL_STAGES = 7;
	localparam int DIV_STAGES = Q_W + 1;
	localparam int GRD_STAGES = 1;
	localparam int PIPE_DEPTH = SCL_STAGES + DIV_STAGES + GRD_STAGES;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VREF_MV    = 3'd0,
		REG_OFFSET_MV  = 3'd1,
		REG_K_GAIN     = 3'd2,
		REG_REF_TEMP   = 3'd3,
		REG_TEMP_COEF  = 3'd4,
		REG_FLOAT_LOW  = 3'd5,
		REG_FLOAT_HIGH = 3'd6,
		REG_CLEAN_MAX  = 3'd7
	} cfg_reg_t;

	typedef enum logic [CLASS_W-1:0] {
		QC_EXCELLENT = 3'd0,
		QC_GOOD      = 3'd1,
		QC_FAIR      = 3'd2,
		QC_POOR      = 3'd3,
		QC_UNACCEPT  = 3'd4,
		QC_DANGEROUS = 3'd5,
		QC_NO_SENSOR = 3'd6
	} quality_t;

	typedef struct packed {
		logic [ADC_W-1:0]        clean_max;
		logic [ADC_W-1:0]        float_high;
		logic [ADC_W-1:0]        float_low;
		logic [COEF_W-1:0]       temp_coef;
		logic signed [TEMP_W-1:0] ref_temp;
		logic [GAIN_W-1:0]       k_gain;
		logic signed [OFS_W-1:0] offset_mv;
		logic [VREF_W-1:0]       vref_mv;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		clean_max:  12'd800,
		float_high: 12'd2400,
		float_low:  12'd1200,
		temp_coef:  16'd1311,
		ref_temp:   12'sd400,
		k_gain:     16'd4096,
		offset_mv:  14'sd0,
		vref_mv:    13'd3300
	};

	// input word, last field in the low bits
	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		logic [ADC_W-1:0]         adc_sample;
	} in_word_t;

	// result word, last field in the low bits
	typedef struct packed {
		logic [CLASS_W-1:0] quality_class;
		logic [TDS_W-1:0]   tds_ppm;
		logic [COND_W-1:0]  conductivity_us;
		logic [VOLT_W-1:0]  voltage_mv;
		logic               sensor_ok;
	} res_t;

	localparam int IN_W  = $bits(in_word_t);
	localparam int OUT_W = $bits(res_t);

	// scaling front end -> divider
	typedef struct packed {
		logic              ok;
		logic [VOLT_W-1:0] volt;
		logic              max_cond;   // factor not positive
		logic              zero_cond;  // compensated voltage not positive
		logic [NUM_W-1:0]  num;
		logic [DEN_W-1:0]  den;
	} scl_t;

	// divider -> grading stage
	typedef struct packed {
		logic              ok;
		logic [VOLT_W-1:0] volt;
		logic              max_cond;
		logic              zero_cond;
		logic              sat;        // quotient would not fit in Q_W bits
		logic [Q_W-1:0]    quo;
	} div_t;

	function automatic logic probe_connected(input logic [ADC_W-1:0] a, input cfg_t c);
		logic r;
		if (a == '0)
			r = 1'b0;
		else if (a >= c.float_low && a <= c.float_high)
			r = 1'b0;
		else if (a <= c.clean_max)
			r = 1'b1;
		else if (a >= ADC_W'(CONDUCTIVE_MIN))
			r = 1'b1;
		else if (a < c.float_low)
			r = 1'b1;
		else
			r = 1'b0;
		return r;
	endfunction

	function automatic logic [TDS_W-1:0] tds_of(input logic [COND_W-1:0] cond);
		logic [TDS_W-1:0] t;
		t = TDS_W'(cond >> 1);
		if (t < TDS_W'(TDS_FLOOR))
			t = TDS_W'(TDS_FLOOR);
		if (t > TDS_W'(TDS_CEILING))
			t = TDS_W'(TDS_CEILING);
		return t;
	endfunction

	function automatic quality_t quality_of(input logic [TDS_W-1:0] t);
		quality_t q;
		if (t <= TDS_W'(QC_LIM_GOOD))
			q = QC_EXCELLENT;
		else if (t <= TDS_W'(QC_LIM_FAIR))
			q = QC_GOOD;
		else if (t <= TDS_W'(QC_LIM_POOR))
			q = QC_FAIR;
		else if (t <= TDS_W'(QC_LIM_UNACC))
			q = QC_POOR;
		else if (t <= TDS_W'(QC_LIM_DANG))
			q = QC_UNACCEPT;
		else
			q = QC_DANGEROUS;
		return q;
	endfunction

endpackage

FILE: hw/rtl/tdsc_scale.sv
// tdsc_scale: seven-stage front end. Millivolt scaling, probe test,
// compensation factor, numerator and denominator of the conductivity quotient.
// Depends on tdsc_pkg.
module tdsc_scale import tdsc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [ADC_W-1:0]         adc_sample,
	input  logic signed [TEMP_W-1:0] temperature,
	input  cfg_t                     cfg,
	output logic                     out_valid,
	input  logic                     out_ready,
	output scl_t                     out_word
);

	logic [SCL_STAGES-1:0] vld_q;
	logic [SCL_STAGES-1:0] vld_nx;
	logic [SCL_STAGES-1:0] en;

	// stage advances when empty or when the stage after it advances
	always_comb begin
		en[SCL_STAGES-1] = !vld_q[SCL_STAGES-1] || out_ready;
		for (int i = SCL_STAGES - 2; i >= 0; i--)
			en[i] = !vld_q[i] || en[i+1];
	end

	assign vld_nx = {vld_q[SCL_STAGES-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (en & vld_nx) | (~en & vld_q);
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[SCL_STAGES-1];

	// stage 1
	logic [PROD_W-1:0]        p_s1;
	logic signed [DIFF_W-1:0] diff_s1;
	logic                     ok_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_s1    <= PROD_W'(adc_sample) * PROD_W'(cfg.vref_mv);
			diff_s1 <= DIFF_W'(temperature) - DIFF_W'(cfg.ref_temp);
			ok_s1   <= probe_connected(adc_sample, cfg);
		end
	end

	// stage 2: quotient estimate, may be one low
	logic [PROD_W+RECIP_W-1:0] qm;
	logic [VQ_W-1:0]           q0_s2;
	logic [PROD_W-1:0]         p_s2;
	logic signed [TP_W-1:0]    tp_s2;
	logic                      ok_s2;

	assign qm = (PROD_W+RECIP_W)'(p_s1) * (PROD_W+RECIP_W)'(RECIP);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			q0_s2 <= VQ_W'(qm >> RECIP_SH);
			p_s2  <= p_s1;
			tp_s2 <= $signed({1'b0, cfg.temp_coef}) * diff_s1;
			ok_s2 <= ok_s1;
		end
	end

	// stage 3
	logic [PROD_W-1:0]     qd_s3;
	logic [VQ_W-1:0]       q0_s3;
	logic [PROD_W-1:0]     p_s3;
	logic signed [F_W-1:0] f_s3;
	logic                  ok_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			qd_s3 <= PROD_W'(q0_s2) * PROD_W'(ADC_FULL_SCALE);
			q0_s3 <= q0_s2;
			p_s3  <= p_s2;
			f_s3  <= F_W'(FACTOR_ONE) + F_W'(tp_s2);
			ok_s3 <= ok_s2;
		end
	end

	// stage 4: correct the estimate, build the denominator
	logic [PROD_W-1:0] rem;
	logic [VREF_W-1:0] vr;
	logic [VQ_W-1:0]   v_s4;
	logic [DEN_W-1:0]  den_s4;
	logic              fpos_s4;
	logic              ok_s4;

	assign rem = p_s3 - qd_s3;
	assign vr  = (cfg.vref_mv == '0) ? VREF_W'(1) : cfg.vref_mv;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			v_s4    <= q0_s3 + VQ_W'(rem >= PROD_W'(ADC_FULL_SCALE));
			den_s4  <= DEN_W'(vr) * DEN_W'(f_s3[FMAG_W-1:0]);
			fpos_s4 <= !f_s3[F_W-1] && (f_s3 != '0);
			ok_s4   <= ok_s3;
		end
	end

	// stage 5: offset removal, reported voltage
	localparam logic [VOLT_W-1:0] VOLT_SAT = '1;

	logic signed [COMP_W-1:0] comp;
	logic [CMAG_W-1:0]        cmag_s5;
	logic                     cpos_s5;
	logic [VOLT_W-1:0]        volt_s5;
	logic [DEN_W-1:0]         den_s5;
	logic                     fpos_s5;
	logic                     ok_s5;

	assign comp = $signed({2'b00, v_s4}) - COMP_W'(cfg.offset_mv);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			cmag_s5 <= comp[CMAG_W-1:0];
			cpos_s5 <= !comp[COMP_W-1] && (comp != '0);
			volt_s5 <= (v_s4 > VQ_W'(VOLT_SAT)) ? VOLT_SAT : v_s4[VOLT_W-1:0];
			den_s5  <= den_s4;
			fpos_s5 <= fpos_s4;
			ok_s5   <= ok_s4;
		end
	end

	// stage 6: times gain
	logic [CK_W-1:0]   ck_s6;
	logic              cpos_s6;
	logic [VOLT_W-1:0] volt_s6;
	logic [DEN_W-1:0]  den_s6;
	logic              fpos_s6;
	logic              ok_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			ck_s6   <= CK_W'(cmag_s5) * CK_W'(cfg.k_gain);
			cpos_s6 <= cpos_s5;
			volt_s6 <= volt_s5;
			den_s6  <= den_s5;
			fpos_s6 <= fpos_s5;
			ok_s6   <= ok_s5;
		end
	end

	// stage 7: times 2000*256, the power-of-two part left to the divider
	logic [NUM_W-1:0]  num_s7;
	logic              cpos_s7;
	logic [VOLT_W-1:0] volt_s7;
	logic [DEN_W-1:0]  den_s7;
	logic              fpos_s7;
	logic              ok_s7;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			num_s7  <= NUM_W'(ck_s6) * NUM_W'(NUM_MUL);
			cpos_s7 <= cpos_s6;
			volt_s7 <= volt_s6;
			den_s7  <= den_s6;
			fpos_s7 <= fpos_s6;
			ok_s7   <= ok_s6;
		end
	end

	always_comb begin
		out_word.ok        = ok_s7;
		out_word.volt      = volt_s7;
		out_word.max_cond  = !fpos_s7;
		out_word.zero_cond = !cpos_s7;
		out_word.num       = num_s7;
		out_word.den       = den_s7;
	end

endmodule

FILE: hw/rtl/tdsc_div.sv
// tdsc_div: pipelined restoring divider, one quotient bit per stage,
// computing (num << Q_W) / den with an overflow flag. Depends on tdsc_pkg.
module tdsc_div import tdsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  scl_t in_word,
	output logic out_valid,
	input  logic out_ready,
	output div_t out_word
);

	logic [DIV_STAGES-1:0] vld_q;
	logic [DIV_STAGES-1:0] vld_nx;
	logic [DIV_STAGES-1:0] en;

	always_comb begin
		en[DIV_STAGES-1] = !vld_q[DIV_STAGES-1] || out_ready;
		for (int i = DIV_STAGES - 2; i >= 0; i--)
			en[i] = !vld_q[i] || en[i+1];
	end

	assign vld_nx = {vld_q[DIV_STAGES-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (en & vld_nx) | (~en & vld_q);
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[DIV_STAGES-1];

	logic [DEN_W-1:0] rem_s  [Q_W];
	logic [DEN_W-1:0] den_s  [Q_W];
	div_t             info_s [DIV_STAGES];

	// stage 0: overflow check; num < den leaves a quotient below 2^Q_W
	div_t info0;

	always_comb begin
		info0.ok        = in_word.ok;
		info0.volt      = in_word.volt;
		info0.max_cond  = in_word.max_cond;
		info0.zero_cond = in_word.zero_cond;
		info0.sat       = DEN_W'(in_word.num) >= in_word.den;
		info0.quo       = '0;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0]  <= DEN_W'(in_word.num);
			den_s[0]  <= in_word.den;
			info_s[0] <= info0;
		end
	end

	for (genvar j = 1; j <= Q_W; j++) begin : g_stage
		logic [DEN_W:0] r2;
		logic           ge;
		div_t           nxt;

		always_comb begin
			r2       = {rem_s[j-1], 1'b0};
			ge       = r2 >= {1'b0, den_s[j-1]};
			nxt      = info_s[j-1];
			nxt.quo  = {info_s[j-1].quo[Q_W-2:0], ge};
		end

		always_ff @(posedge clk) begin
			if (en[j])
				info_s[j] <= nxt;
		end

		if (j < Q_W) begin : g_rem
			always_ff @(posedge clk) begin
				if (en[j]) begin
					rem_s[j] <= ge ? DEN_W'(r2 - {1'b0, den_s[j-1]}) : DEN_W'(r2);
					den_s[j] <= den_s[j-1];
				end
			end
		end
	end

	assign out_word = info_s[Q_W];

endmodule

FILE: hw/rtl/tdsc_grade.sv
// tdsc_grade: output stage. Clamps conductivity, derives TDS and the quality
// class, holds the result word for the master side. Depends on tdsc_pkg.
module tdsc_grade import tdsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  div_t in_word,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_word
);

	logic vld_s1;
	logic en;
	res_t res;
	res_t res_s1;
	logic [COND_W-1:0] cond;

	assign en = !vld_s1 || out_ready;

	always_comb begin
		if (!in_word.ok)
			cond = '0;
		else if (in_word.max_cond)
			cond = COND_W'(COND_MAX);
		else if (in_word.zero_cond)
			cond = '0;
		else if (in_word.sat || COND_W'(in_word.quo) > COND_W'(COND_MAX))
			cond = COND_W'(COND_MAX);
		else
			cond = COND_W'(in_word.quo);

		res.sensor_ok       = in_word.ok;
		res.voltage_mv      = in_word.volt;
		res.conductivity_us = cond;
		if (in_word.ok) begin
			res.tds_ppm       = tds_of(cond);
			res.quality_class = quality_of(tds_of(cond));
		end else begin
			res.tds_ppm       = '0;
			res.quality_class = QC_NO_SENSOR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			res_s1 <= res;
	end

	assign in_ready  = en;
	assign out_valid = vld_s1;
	assign out_word  = res_s1;

endmodule

FILE: hw/rtl/tds_sample_converter.sv
// tds_sample_converter: top level. Configuration registers and the three
// pipeline parts. Depends on tdsc_pkg, tdsc_scale, tdsc_div, tdsc_grade.
//
//  port group   dir  width  contents
//  s_t*         in   24     tdata: adc_sample[11:0], temperature[23:12]
//  m_t*         out  40     tdata: sensor_ok, voltage_mv, conductivity_us, tds_ppm, class
//  cfg_*        in   1+3+16 write enable, register index, write data
//
// One word per cycle in and out while m_tready stays high. The path holds 7 scaling
// stages, the 13-stage divider (one quotient bit per stage) and the output register.
// Reset clears all valid bits and loads the register defaults.
// Each stage moves on when it is empty or the next stage moves, so a stalled
// output holds its word while bubbles ahead of it still fill.
module tds_sample_converter import tdsc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,   // adc_sample[11:0], temperature[23:12]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // sensor_ok[0], voltage_mv[13:1],
	                                        // conductivity_us[25:14], tds_ppm[36:26],
	                                        // quality_class[39:37]
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_VREF_MV:    cfg_q.vref_mv    <= cfg_wdata[VREF_W-1:0];
				REG_OFFSET_MV:  cfg_q.offset_mv  <= cfg_wdata[OFS_W-1:0];
				REG_K_GAIN:     cfg_q.k_gain     <= cfg_wdata[GAIN_W-1:0];
				REG_REF_TEMP:   cfg_q.ref_temp   <= cfg_wdata[TEMP_W-1:0];
				REG_TEMP_COEF:  cfg_q.temp_coef  <= cfg_wdata[COEF_W-1:0];
				REG_FLOAT_LOW:  cfg_q.float_low  <= cfg_wdata[ADC_W-1:0];
				REG_FLOAT_HIGH: cfg_q.float_high <= cfg_wdata[ADC_W-1:0];
				REG_CLEAN_MAX:  cfg_q.clean_max  <= cfg_wdata[ADC_W-1:0];
			endcase
		end
	end

	in_word_t in_word;
	assign in_word = in_word_t'(s_tdata);

	logic scl_valid;
	logic scl_ready;
	scl_t scl_word;
	logic div_valid;
	logic div_ready;
	div_t div_word;
	res_t res_word;

	tdsc_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.adc_sample  (in_word.adc_sample),
		.temperature (in_word.temperature),
		.cfg         (cfg_q),
		.out_valid   (scl_valid),
		.out_ready   (scl_ready),
		.out_word    (scl_word)
	);

	tdsc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (scl_valid),
		.in_ready  (scl_ready),
		.in_word   (scl_word),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_word  (div_word)
	);

	tdsc_grade u_grade (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_word   (div_word),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (res_word)
	);

	assign m_tdata = res_word;

endmodule

FILE: hw/rtl/tdsc_checker.sv
// tdsc_checker: port-level assertions for tds_sample_converter, attached by
// the bind at the end of this file. Depends on tdsc_pkg.
module tdsc_checker import tdsc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

	res_t             r;
	in_word_t         w;
	logic [CNT_W-1:0] inflight_q;
	logic             in_acc;
	logic             out_acc;

	assign r       = res_t'(m_tdata);
	assign w       = in_word_t'(s_tdata);
	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// words taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	a_no_sensor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !r.sensor_ok |->
			r.conductivity_us == '0 && r.tds_ppm == '0 && r.quality_class == QC_NO_SENSOR)
		else $error("disconnected word carries readings");

	a_grading: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.sensor_ok |->
			r.conductivity_us <= COND_W'(COND_MAX) && r.tds_ppm == tds_of(r.conductivity_us)
			&& r.quality_class == quality_of(r.tds_ppm))
		else $error("conductivity, tds and class disagree");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output word changed");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(PIPE_DEPTH) && (!m_tvalid || inflight_q != '0))
		else $error("word count in flight out of range");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == CNT_W'(PIPE_DEPTH) && !m_tready |-> !s_tready)
		else $error("full pipeline still accepts, temp %0d", w.temperature);

endmodule

bind tds_sample_converter tdsc_checker u_tdsc_checker (.*);

FILE: bench/tb.sv
// tb: self-checking bench for tds_sample_converter. Holds a bit-exact predictor of the
// sample conversion and checks every output word in order. Depends on tdsc_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
	import tdsc_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;   // adc_sample[11:0], temperature[23:12]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;   // sensor_ok, voltage_mv, conductivity_us, tds_ppm,
	                                 // quality_class
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	tds_sample_converter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// bench copy of the register file
	logic [VREF_W-1:0]        vref_q;
	logic signed [OFS_W-1:0]  ofs_q;
	logic [GAIN_W-1:0]        gain_q;
	logic signed [TEMP_W-1:0] tref_q;
	logic [COEF_W-1:0]        coef_q;
	logic [ADC_W-1:0]         flo_q;
	logic [ADC_W-1:0]         fhi_q;
	logic [ADC_W-1:0]         cmax_q;

	res_t pending_results[$];
	bit   idle_on = 1'b1;
	int   fail_count = 0;
	int   n_samples = 0;
	int   n_checked = 0;
	int   n_settings = 0;
	int   class_seen[8];

	always #4 clk = ~clk;

	function automatic res_t convert_sample(in_word_t w);
		longint adc, volt, ofs, comp, tdiff, factor, num, den, cond, tds, vr;
		logic signed [TEMP_W-1:0] t;
		logic [ADC_W-1:0] a;
		logic link;
		res_t r;
		a = w.adc_sample;
		t = w.temperature;
		adc = longint'(a);
		vr = longint'(vref_q);
		ofs = longint'(ofs_q);
		volt = adc * vr / ADC_FULL_SCALE;
		r.voltage_mv = (volt > 8191) ? '1 : VOLT_W'(volt);
		if (a == '0)
			link = 1'b0;
		else if (a >= flo_q && a <= fhi_q)
			link = 1'b0;
		else if (a <= cmax_q || a >= ADC_W'(CONDUCTIVE_MIN) || a < flo_q)
			link = 1'b1;
		else
			link = 1'b0;
		r.sensor_ok = link;
		if (!link) begin
			r.conductivity_us = '0;
			r.tds_ppm = '0;
			r.quality_class = QC_NO_SENSOR;
			return r;
		end
		comp = volt - ofs;
		tdiff = longint'(t) - longint'(tref_q);
		factor = longint'(FACTOR_ONE) + longint'(coef_q) * tdiff;
		if (factor <= 0) begin
			cond = COND_MAX;
		end else if (comp <= 0) begin
			cond = 0;
		end else begin
			if (vr == 0)
				vr = 1;
			num = comp * 2000 * longint'(gain_q) * 256;
			den = vr * factor;
			cond = num / den;
			if (cond > COND_MAX)
				cond = COND_MAX;
		end
		tds = cond / 2;
		if (tds < TDS_FLOOR)
			tds = TDS_FLOOR;
		if (tds > TDS_CEILING)
			tds = TDS_CEILING;
		r.conductivity_us = COND_W'(cond);
		r.tds_ppm = TDS_W'(tds);
		if (tds <= QC_LIM_GOOD)
			r.quality_class = QC_EXCELLENT;
		else if (tds <= QC_LIM_FAIR)
			r.quality_class = QC_GOOD;
		else if (tds <= QC_LIM_POOR)
			r.quality_class = QC_FAIR;
		else if (tds <= QC_LIM_UNACC)
			r.quality_class = QC_POOR;
		else if (tds <= QC_LIM_DANG)
			r.quality_class = QC_UNACCEPT;
		else
			r.quality_class = QC_DANGEROUS;
		return r;
	endfunction

	// output side: random backpressure while idle_on is set, then compare against the oldest prediction
	always @(posedge clk) begin
		m_tready <= !idle_on || ($urandom_range(0, 99) >= 30);
	end

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				$error("unexpected output word %h", m_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				class_seen[got.quality_class]++;
				if (got.sensor_ok !== want.sensor_ok) begin
					$error("sensor_ok exp %0d got %0d", want.sensor_ok, got.sensor_ok);
					fail_count++;
				end
				if (got.voltage_mv !== want.voltage_mv) begin
					$error("voltage_mv exp %0d got %0d", want.voltage_mv, got.voltage_mv);
					fail_count++;
				end
				if (got.conductivity_us !== want.conductivity_us) begin
					$error("conductivity_us exp %0d got %0d", want.conductivity_us,
						got.conductivity_us);
					fail_count++;
				end
				if (got.tds_ppm !== want.tds_ppm) begin
					$error("tds_ppm exp %0d got %0d", want.tds_ppm, got.tds_ppm);
					fail_count++;
				end
				if (got.quality_class !== want.quality_class) begin
					$error("quality_class exp %0d got %0d", want.quality_class,
						got.quality_class);
					fail_count++;
				end
			end
		end
	end

	task automatic send_sample(input logic [ADC_W-1:0] adc, input logic [TEMP_W-1:0] temp);
		in_word_t w;
		w.adc_sample = adc;
		w.temperature = temp;
		while (idle_on && $urandom_range(0, 99) < 30) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(convert_sample(w));
		n_samples++;
	endtask

	// every word yields one result, so an empty queue means an empty pipeline
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_VREF_MV:    vref_q = val[VREF_W-1:0];
			REG_OFFSET_MV:  ofs_q = val[OFS_W-1:0];
			REG_K_GAIN:     gain_q = val[GAIN_W-1:0];
			REG_REF_TEMP:   tref_q = val[TEMP_W-1:0];
			REG_TEMP_COEF:  coef_q = val[COEF_W-1:0];
			REG_FLOAT_LOW:  flo_q = val[ADC_W-1:0];
			REG_FLOAT_HIGH: fhi_q = val[ADC_W-1:0];
			REG_CLEAN_MAX:  cmax_q = val[ADC_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input int vref, input int ofs, input int gain, input int tref,
			input int coef, input int flo, input int fhi, input int cmax);
		wait_idle();
		write_reg(REG_VREF_MV, CFG_W'(vref));
		write_reg(REG_OFFSET_MV, CFG_W'(ofs));
		write_reg(REG_K_GAIN, CFG_W'(gain));
		write_reg(REG_REF_TEMP, CFG_W'(tref));
		write_reg(REG_TEMP_COEF, CFG_W'(coef));
		write_reg(REG_FLOAT_LOW, CFG_W'(flo));
		write_reg(REG_FLOAT_HIGH, CFG_W'(fhi));
		write_reg(REG_CLEAN_MAX, CFG_W'(cmax));
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// reset register values: band edges, zero sample, hot and cold water
	task automatic test_band_edges();
		send_sample(12'd0, 12'd400);
		send_sample(12'd1, 12'd400);
		send_sample(12'd800, 12'd400);
		send_sample(12'd801, 12'd400);
		send_sample(12'd1199, 12'd400);
		send_sample(12'd1200, 12'd400);
		send_sample(12'd2400, 12'd400);
		send_sample(12'd2401, 12'd400);
		send_sample(12'd2499, 12'd400);
		send_sample(12'd2500, 12'd400);
		send_sample(12'd4095, 12'd400);
		send_sample(12'd4095, 12'd2000);
		send_sample(12'd4095, -12'sd640);
		send_sample(12'd3000, 12'd2047);
		send_sample(12'd2600, -12'sd2048);
		send_sample(12'd700, 12'h2AA);
	endtask

	task automatic test_corner_settings();
		// compensation factor driven to zero or below
		set_regs(3300, 0, 4096, 2000, 65535, 1200, 2400, 800);
		send_sample(12'd4095, -12'sd640);
		send_sample(12'd100, 12'd2000);
		// offset swallows the whole voltage
		set_regs(3300, 5000, 4096, 400, 1311, 1200, 2400, 800);
		send_sample(12'd4095, 12'd400);
		// zero reference with a negative offset
		set_regs(0, -5000, 4096, 400, 1311, 1200, 2400, 800);
		send_sample(12'd4095, 12'd400);
		send_sample(12'd1, 12'd400);
		// all-ones write to the reference, widest gain
		set_regs(16'hFFFF, 0, 65535, 400, 1311, 1200, 2400, 800);
		send_sample(12'd4095, 12'd400);
		send_sample(12'd2600, 12'd1000);
	endtask

	task automatic test_random_settings();
		int a;
		logic [TEMP_W-1:0] tv;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_regs(3300, 0, 4096, 400, 1311, 1200, 2400, 800);
				1: set_regs(1, -5000, 0, -640, 0, 0, 0, 0);
				2: set_regs(5000, 5000, 65535, 2000, 65535, 4095, 4095, 4095);
				default: set_regs(
					($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(1, 5000),
					int'($urandom_range(0, 10000)) - 5000,
					$urandom_range(0, 65535),
					int'($urandom_range(0, 2640)) - 640,
					$urandom_range(0, 1) ? $urandom_range(0, 4000) : $urandom_range(0, 65535),
					$urandom_range(0, 4095),
					$urandom_range(0, 4095),
					$urandom_range(0, 4095));
			endcase
			idle_on = (p != 4);
			for (int k = 0; k < 106; k++) begin
				case ($urandom_range(0, 9))
					0: a = 0;
					1: a = int'(flo_q) + int'($urandom_range(0, 2)) - 1;
					2: a = int'(fhi_q) + int'($urandom_range(0, 2)) - 1;
					3: a = int'(cmax_q) + int'($urandom_range(0, 2)) - 1;
					4: a = CONDUCTIVE_MIN + int'($urandom_range(0, 2)) - 1;
					5: a = 4095;
					default: a = $urandom_range(0, 4095);
				endcase
				if (a < 0)
					a = 0;
				if (a > 4095)
					a = 4095;
				if ($urandom_range(0, 9) == 0)
					tv = TEMP_W'($urandom_range(0, 4095));
				else
					tv = TEMP_W'(int'($urandom_range(0, 2640)) - 640);
				send_sample(ADC_W'(a), tv);
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		clk = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		m_tready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_VREF_MV;
		cfg_wdata <= '0;
		vref_q = CFG_RESET.vref_mv;
		ofs_q = CFG_RESET.offset_mv;
		gain_q = CFG_RESET.k_gain;
		tref_q = CFG_RESET.ref_temp;
		coef_q = CFG_RESET.temp_coef;
		flo_q = CFG_RESET.float_low;
		fhi_q = CFG_RESET.float_high;
		cmax_q = CFG_RESET.clean_max;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_band_edges();
		test_corner_settings();
		test_random_settings();

		wait_idle();
		repeat (PIPE_DEPTH + 8) @(posedge clk);
		$display("%0d samples over %0d register settings, %0d words checked", n_samples,
			n_settings, n_checked);
		$display("classes seen 0..6: %0d %0d %0d %0d %0d %0d %0d", class_seen[0],
			class_seen[1], class_seen[2], class_seen[3], class_seen[4], class_seen[5],
			class_seen[6]);
		if (fail_count == 0)
			$display("tds_sample_converter verification clean");
		else
			$display("tds_sample_converter verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tds_sample_converter verification failed");
		$finish;
	end

endmodule
